[src/gf2_systematic_gauss_elim_defines.svh]
// assertion macros for the gf2 elimination block
`ifndef GF2_SYSTEMATIC_GAUSS_ELIM_DEFINES_SVH
`define GF2_SYSTEMATIC_GAUSS_ELIM_DEFINES_SVH

// same-cycle implication under an active-low reset
`define GSE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gf2 elimination check failed");

// next-cycle implication under an active-low reset
`define GSE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gf2 elimination check failed");

`endif

[src/gse_pkg.sv]
package gse_pkg;

  // matrix geometry
  localparam int MAX_ROWS      = 768;
  localparam int WORDS_PER_ROW = 109;
  localparam int WORD_BITS     = 32;

  localparam int DEPTH  = MAX_ROWS * WORDS_PER_ROW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NR_W   = $clog2(MAX_ROWS + 1);
  localparam int NW_W   = $clog2(WORDS_PER_ROW + 1);
  localparam int BIT_W  = $clog2(WORD_BITS);

  // fixed field widths
  localparam int ROWS_REG_W  = 10;
  localparam int WORDS_REG_W = 7;
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 1;

  // opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORDS = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  row_index;
    logic [6:0]  word_index;
    logic [31:0] data_word;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        status;
    logic [9:0]  failed_row;
  } res_t;

  // row-major word address
  function automatic logic [ADDR_W-1:0] store_addr(input logic [NR_W-1:0] row,
                                                   input logic [NW_W-1:0] word);
    store_addr = ADDR_W'(row) * ADDR_W'(WORDS_PER_ROW) + ADDR_W'(word);
  endfunction

endpackage

[src/gse_ram.sv]
module gse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/gf2_systematic_gauss_elim.sv]
// channel   | ports                              | transfer
// ----------+------------------------------------+-----------------------------
// command   | start, busy, cmd_i                 | start high while busy low
// result    | done_o, res_o                      | done_o high for one cycle
// config    | cfg_we_i, cfg_idx_i, cfg_data_i    | cfg_we_i high, no wait
//
// write and read commands leave busy low; the result strobe follows in the cycle
// after the transfer, and a new command is taken in that same cycle.
// a run holds busy while each pivot row is found, checked and cleared from the
// other rows; each row addition reads through the single read port of the store.
// reset sets both registers to the full matrix size, 768 rows and 109 words,
// and clears the sequencer; the store itself is not cleared, words read before
// a write are undefined. results cannot be held off by the receiver.
`include "gf2_systematic_gauss_elim_defines.svh"

module gf2_systematic_gauss_elim
  import gse_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd_i,
  output logic                  done_o,
  output res_t                  res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_PIV_RD = 11'b00000000010,
    S_PIV_CK = 11'b00000000100,
    S_FWD_RD = 11'b00000001000,
    S_FWD_CK = 11'b00000010000,
    S_CHK    = 11'b00000100000,
    S_BWD_RD = 11'b00001000000,
    S_BWD_CK = 11'b00010000000,
    S_ADD_RS = 11'b00100000000,
    S_ADD_RD = 11'b01000000000,
    S_ADD_WR = 11'b10000000000
  } state_e;

  state_e                 state_q, state_d;
  logic [ROWS_REG_W-1:0]  rows_q;
  logic [WORDS_REG_W-1:0] words_q;
  logic [NR_W-1:0]        nrows_q, nrows_d;
  logic [NW_W-1:0]        nwords_q, nwords_d;
  logic [NR_W-1:0]        r_q, r_d, k_q, k_d;
  logic [NW_W-1:0]        c_q, c_d;
  logic                   ret_bwd_q, ret_bwd_d;
  logic                   piv_q, piv_d;
  logic                   res_valid_q, res_valid_d;
  logic                   res_read_q, res_read_d;
  logic                   status_q, status_d;
  logic [9:0]             failed_q, failed_d;
  logic [NR_W-1:0]        src_q, src_d, dst_q, dst_d;
  logic [WORD_BITS-1:0]   tmp_q, tmp_d;

  logic                   ram_re, ram_we;
  logic [NR_W-1:0]        rd_row, wr_row;
  logic [NW_W-1:0]        rd_word, wr_word;
  logic [WORD_BITS-1:0]   ram_wdata, ram_rdata;

  logic [NR_W-1:0]        pw;
  logic [NW_W-1:0]        pw_word;
  logic                   pw_in_row, pw_in_use, bit_val;
  logic [NR_W-1:0]        k_inc, r_inc;
  logic [NW_W-1:0]        c_inc;
  logic                   addr_ok;
  logic [NR_W-1:0]        run_rows;
  logic [NW_W-1:0]        run_words;
  logic                   fwd_adv, bwd_adv;

  // matrix store
  gse_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (store_addr(wr_row, wr_word)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (store_addr(rd_row, rd_word)),
    .rdata_o (ram_rdata)
  );

  // pivot column position of the current row
  assign pw        = r_q >> BIT_W;
  assign pw_word   = NW_W'(pw);
  assign pw_in_row = 32'(pw) < 32'(WORDS_PER_ROW);
  assign pw_in_use = 32'(pw) < 32'(nwords_q);
  assign bit_val   = ram_rdata[BIT_W'(r_q)] & pw_in_row;

  assign k_inc = k_q + 1'b1;
  assign r_inc = r_q + 1'b1;
  assign c_inc = c_q + 1'b1;

  // command decode helpers
  assign addr_ok   = (32'(cmd_i.row_index) < 32'(MAX_ROWS)) &&
                     (32'(cmd_i.word_index) < 32'(WORDS_PER_ROW));
  assign run_rows  = (32'(rows_q) > 32'(MAX_ROWS)) ? NR_W'(MAX_ROWS) : NR_W'(rows_q);
  assign run_words = (32'(words_q) > 32'(WORDS_PER_ROW)) ? NW_W'(WORDS_PER_ROW)
                                                         : NW_W'(words_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    nrows_d     = nrows_q;
    nwords_d    = nwords_q;
    r_d         = r_q;
    k_d         = k_q;
    c_d         = c_q;
    ret_bwd_d   = ret_bwd_q;
    piv_d       = piv_q;
    res_valid_d = 1'b0;
    res_read_d  = 1'b0;
    status_d    = status_q;
    failed_d    = failed_q;
    src_d       = src_q;
    dst_d       = dst_q;
    tmp_d       = tmp_q;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    rd_row      = k_q;
    rd_word     = pw_word;
    wr_row      = dst_q;
    wr_word     = c_q;
    ram_wdata   = ram_rdata ^ tmp_q;
    fwd_adv     = 1'b0;
    bwd_adv     = 1'b0;

    case (state_q)
      S_IDLE: begin
        rd_row  = NR_W'(cmd_i.row_index);
        rd_word = NW_W'(cmd_i.word_index);
        wr_row  = NR_W'(cmd_i.row_index);
        wr_word = NW_W'(cmd_i.word_index);
        ram_wdata = WORD_BITS'(cmd_i.data_word);
        if (start) begin
          status_d = 1'b0;
          failed_d = '0;
          case (cmd_i.opcode)
            OP_WRITE: begin
              ram_we      = addr_ok;
              res_valid_d = 1'b1;
            end
            OP_READ: begin
              ram_re      = 1'b1;
              res_valid_d = 1'b1;
              res_read_d  = addr_ok;
            end
            OP_RUN: begin
              nrows_d  = run_rows;
              nwords_d = run_words;
              r_d      = '0;
              if (run_rows == '0) begin
                res_valid_d = 1'b1;
              end else begin
                state_d = S_PIV_RD;
              end
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_PIV_RD: begin
        ram_re  = 1'b1;
        rd_row  = r_q;
        state_d = S_PIV_CK;
      end
      S_PIV_CK: begin
        piv_d = bit_val;
        if (r_inc == nrows_q) begin
          state_d = S_CHK;
        end else begin
          k_d     = r_inc;
          state_d = S_FWD_RD;
        end
      end
      S_FWD_RD: begin
        ram_re  = 1'b1;
        state_d = S_FWD_CK;
      end
      S_FWD_CK: begin
        if ((piv_q != bit_val) && (nwords_q != '0)) begin
          piv_d     = piv_q ^ (bit_val & pw_in_use);
          dst_d     = r_q;
          src_d     = k_q;
          c_d       = '0;
          ret_bwd_d = 1'b0;
          state_d   = S_ADD_RS;
        end else begin
          fwd_adv = 1'b1;
        end
      end
      S_CHK: begin
        if (!piv_q) begin
          res_valid_d = 1'b1;
          status_d    = 1'b1;
          failed_d    = 10'(r_q);
          state_d     = S_IDLE;
        end else begin
          k_d     = '0;
          state_d = S_BWD_RD;
        end
      end
      S_BWD_RD: begin
        if (k_q == r_q) begin
          bwd_adv = 1'b1;
        end else begin
          ram_re  = 1'b1;
          state_d = S_BWD_CK;
        end
      end
      S_BWD_CK: begin
        if (bit_val && (nwords_q != '0)) begin
          dst_d     = k_q;
          src_d     = r_q;
          c_d       = '0;
          ret_bwd_d = 1'b1;
          state_d   = S_ADD_RS;
        end else begin
          bwd_adv = 1'b1;
        end
      end
      S_ADD_RS: begin
        ram_re  = 1'b1;
        rd_row  = src_q;
        rd_word = c_q;
        state_d = S_ADD_RD;
      end
      S_ADD_RD: begin
        ram_re  = 1'b1;
        rd_row  = dst_q;
        rd_word = c_q;
        tmp_d   = ram_rdata;
        state_d = S_ADD_WR;
      end
      S_ADD_WR: begin
        ram_we = 1'b1;
        if (c_inc == nwords_q) begin
          fwd_adv = !ret_bwd_q;
          bwd_adv = ret_bwd_q;
        end else begin
          // next source word goes out while this word is written back
          ram_re  = 1'b1;
          rd_row  = src_q;
          rd_word = c_inc;
          c_d     = c_inc;
          state_d = S_ADD_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // next later row in the forward pass
    if (fwd_adv) begin
      if (k_inc == nrows_q) begin
        state_d = S_CHK;
      end else begin
        k_d     = k_inc;
        state_d = S_FWD_RD;
      end
    end

    // next row in the clearing pass, then next pivot
    if (bwd_adv) begin
      if (k_inc == nrows_q) begin
        if (r_inc == nrows_q) begin
          res_valid_d = 1'b1;
          status_d    = 1'b0;
          failed_d    = '0;
          state_d     = S_IDLE;
        end else begin
          r_d     = r_inc;
          state_d = S_PIV_RD;
        end
      end else begin
        k_d     = k_inc;
        state_d = S_BWD_RD;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_q      <= ROWS_REG_W'(768);
      words_q     <= WORDS_REG_W'(109);
      nrows_q     <= '0;
      nwords_q    <= '0;
      r_q         <= '0;
      k_q         <= '0;
      c_q         <= '0;
      ret_bwd_q   <= 1'b0;
      piv_q       <= 1'b0;
      res_valid_q <= 1'b0;
      res_read_q  <= 1'b0;
      status_q    <= 1'b0;
      failed_q    <= '0;
    end else begin
      state_q     <= state_d;
      nrows_q     <= nrows_d;
      nwords_q    <= nwords_d;
      r_q         <= r_d;
      k_q         <= k_d;
      c_q         <= c_d;
      ret_bwd_q   <= ret_bwd_d;
      piv_q       <= piv_d;
      res_valid_q <= res_valid_d;
      res_read_q  <= res_read_d;
      status_q    <= status_d;
      failed_q    <= failed_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROWS:  rows_q  <= cfg_data_i[ROWS_REG_W-1:0];
          CFG_WORDS: words_q <= cfg_data_i[WORDS_REG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // row addition operands
  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    dst_q <= dst_d;
    tmp_q <= tmp_d;
  end

  // outputs
  assign busy             = (state_q != S_IDLE);
  assign done_o           = res_valid_q;
  assign res_o.read_data  = res_read_q ? 32'(ram_rdata) : 32'd0;
  assign res_o.status     = status_q;
  assign res_o.failed_row = failed_q;

  // checks
  `GSE_ASSERT_IMP(a_run_end_strobe, clk_i, rst_ni, $fell(busy), done_o)
  `GSE_ASSERT_IMP(a_strobe_cause, clk_i, rst_ni, done_o, $past(start && !busy) || $past(busy))
  `GSE_ASSERT_IMP(a_run_write_only_add, clk_i, rst_ni, ram_we && busy, state_q == S_ADD_WR)
  `GSE_ASSERT_IMP(a_add_word_range, clk_i, rst_ni, state_q == S_ADD_WR, c_q < nwords_q)

endmodule
